// ===== rtl/core/ttps_pkg.sv =====
// Package for the transposition table probe/store block.
// Table geometry, action codes, entry layout and result struct; no dependencies.
`default_nettype none

package ttps_pkg;

  localparam int IDX_W   = 10;
  localparam int ENTRIES = 1 << IDX_W;

  localparam int KEY_W   = 64;
  localparam int MOVE_W  = 25;
  localparam int SCORE_W = 16;
  localparam int DEPTH_W = 6;
  localparam int BOUND_W = 2;
  localparam int CNT_W   = 32;

  localparam int MATE_EDGE = 29000;
  localparam int MAX_PLY   = 64;

  typedef enum logic [1:0] {
    ACT_STORE = 2'd0,
    ACT_PROBE = 2'd1,
    ACT_CLEAR = 2'd2
  } act_t;

  localparam logic [BOUND_W-1:0] BND_ALPHA = 2'd1;
  localparam logic [BOUND_W-1:0] BND_BETA  = 2'd2;
  localparam logic [BOUND_W-1:0] BND_EXACT = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0]        depth;
    logic [BOUND_W-1:0]        bound;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic                      matched;
    logic [MOVE_W-1:0]         move;
    logic                      usable;
    logic signed [SCORE_W-1:0] score;
    logic                      hit;
  } probe_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/ttps_req_if.sv =====
// Request channel: one table operation word per handshake.
// Depends on ttps_pkg for field widths.
`default_nettype none

interface ttps_req_if;
  logic                                        valid;
  logic                                        ready;
  logic [1:0]                                  action;
  logic [ttps_pkg::KEY_W-1:0]                  position_key;
  logic [ttps_pkg::MOVE_W-1:0]                 store_move;
  logic signed [ttps_pkg::SCORE_W-1:0]         store_score;
  logic [ttps_pkg::BOUND_W-1:0]                bound_kind;
  logic [ttps_pkg::DEPTH_W-1:0]                req_depth;
  logic [ttps_pkg::DEPTH_W-1:0]                ply_now;
  logic signed [ttps_pkg::SCORE_W-1:0]         alpha_bound;
  logic signed [ttps_pkg::SCORE_W-1:0]         beta_bound;

  modport source (output valid, action, position_key, store_move, store_score,
                  bound_kind, req_depth, ply_now, alpha_bound, beta_bound,
                  input ready);
  modport sink   (input valid, action, position_key, store_move, store_score,
                  bound_kind, req_depth, ply_now, alpha_bound, beta_bound,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ttps_rsp_if.sv =====
// Response channel: one result word per request word.
// Depends on ttps_pkg for field widths.
`default_nettype none

interface ttps_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                matched;
  logic [ttps_pkg::MOVE_W-1:0]         found_move;
  logic                                usable;
  logic signed [ttps_pkg::SCORE_W-1:0] found_score;
  logic [ttps_pkg::CNT_W-1:0]          new_writes;
  logic [ttps_pkg::CNT_W-1:0]          over_writes;
  logic [ttps_pkg::CNT_W-1:0]          hit_count;

  modport source (output valid, matched, found_move, usable, found_score,
                  new_writes, over_writes, hit_count, input ready);
  modport sink   (input valid, matched, found_move, usable, found_score,
                  new_writes, over_writes, hit_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ttps_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data.
// Read data holds when no read is issued. No dependencies.
`default_nettype none

module ttps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ttps_score_unit.sv =====
// Score logic: mate ply shift on store, match/depth/bound evaluation on probe.
// Depends on ttps_pkg for the entry layout and result struct.
`default_nettype none

module ttps_score_unit (
  input  wire ttps_pkg::entry_t                    slot,
  input  wire logic [ttps_pkg::KEY_W-1:0]          key,
  input  wire logic signed [ttps_pkg::SCORE_W-1:0] store_score,
  input  wire logic [ttps_pkg::DEPTH_W-1:0]        req_depth,
  input  wire logic [ttps_pkg::DEPTH_W-1:0]        ply_now,
  input  wire logic signed [ttps_pkg::SCORE_W-1:0] alpha_bound,
  input  wire logic signed [ttps_pkg::SCORE_W-1:0] beta_bound,
  output logic signed [ttps_pkg::SCORE_W-1:0]      stored_score,
  output ttps_pkg::probe_res_t                     res
);

  localparam int XW = ttps_pkg::SCORE_W + 1;
  localparam logic signed [XW-1:0] MATE_HI =
    XW'(ttps_pkg::MATE_EDGE - ttps_pkg::MAX_PLY);
  localparam logic signed [XW-1:0] MATE_LO =
    XW'(-ttps_pkg::MATE_EDGE - ttps_pkg::MAX_PLY);
  localparam logic signed [ttps_pkg::SCORE_W-1:0] S_MAX =
    {1'b0, {(ttps_pkg::SCORE_W-1){1'b1}}};
  localparam logic signed [ttps_pkg::SCORE_W-1:0] S_MIN =
    {1'b1, {(ttps_pkg::SCORE_W-1){1'b0}}};

  logic signed [XW-1:0] sc_x;
  logic signed [XW-1:0] ply_x;
  logic signed [XW-1:0] sh;
  logic signed [XW-1:0] fs_x;
  logic signed [ttps_pkg::SCORE_W-1:0] fs;

  assign ply_x = signed'(XW'(ply_now));
  assign sc_x  = XW'(store_score);

  always_comb begin
    sh = sc_x;
    if (sc_x > MATE_HI) begin
      sh = sc_x + ply_x;
    end else if (sc_x < MATE_LO) begin
      sh = sc_x - ply_x;
    end
    if (sh[XW-1] != sh[XW-2]) begin
      stored_score = sh[XW-1] ? S_MIN : S_MAX;
    end else begin
      stored_score = sh[ttps_pkg::SCORE_W-1:0];
    end
  end

  always_comb begin
    fs_x = XW'(slot.score);
    if (fs_x > MATE_HI) begin
      fs_x = fs_x - ply_x;
    end else if (fs_x < MATE_LO) begin
      fs_x = fs_x + ply_x;
    end
    fs = fs_x[ttps_pkg::SCORE_W-1:0];

    res = '0;
    if (slot.key == key) begin
      res.matched = 1'b1;
      res.move    = slot.move;
      if (slot.depth >= req_depth) begin
        res.hit   = 1'b1;
        res.score = fs;
        unique case (slot.bound)
          ttps_pkg::BND_ALPHA: begin
            if (fs <= alpha_bound) begin
              res.score  = alpha_bound;
              res.usable = 1'b1;
            end
          end
          ttps_pkg::BND_BETA: begin
            if (fs >= beta_bound) begin
              res.score  = beta_bound;
              res.usable = 1'b1;
            end
          end
          ttps_pkg::BND_EXACT: res.usable = 1'b1;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/transposition_table_probe_store.sv =====
// Top level: direct-mapped transposition table with probe, store and clear.
// Depends on ttps_pkg, ttps_req_if, ttps_rsp_if, ttps_ram, ttps_score_unit.
//
//   channel | dir | word
//   req     | in  | action, key, move, score, bound, depth, ply, alpha, beta
//   rsp     | out | matched, move, usable, score, three counters
//
// Store and probe: table read on accept, then evaluate and, for a store, write back.
// Clear: a sweep through all ENTRIES addresses of the table RAM, then the result word.
// After reset a sweep of all ENTRIES (1024) addresses zeroes the table; req.ready is low.
// A stalled rsp holds the block in its evaluate state with the read data kept.
`default_nettype none

module transposition_table_probe_store (
  input wire logic   clk,
  input wire logic   rst,
  ttps_req_if.sink   req,
  ttps_rsp_if.source rsp
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LOOK  = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [1:0]                          action;
  logic [ttps_pkg::KEY_W-1:0]          position_key;
  logic [ttps_pkg::MOVE_W-1:0]         store_move;
  logic signed [ttps_pkg::SCORE_W-1:0] store_score;
  logic [ttps_pkg::BOUND_W-1:0]        bound_kind;
  logic [ttps_pkg::DEPTH_W-1:0]        req_depth;
  logic [ttps_pkg::DEPTH_W-1:0]        ply_now;
  logic signed [ttps_pkg::SCORE_W-1:0] alpha_bound;
  logic signed [ttps_pkg::SCORE_W-1:0] beta_bound;

  logic [ttps_pkg::IDX_W-1:0] clr_addr;
  logic                       clr_report;
  logic [ttps_pkg::CNT_W-1:0] new_write_total;
  logic [ttps_pkg::CNT_W-1:0] over_write_total;
  logic [ttps_pkg::CNT_W-1:0] hit_total;

  logic                       accept;
  logic                       out_free;
  logic                       look_done;
  logic                       clr_last;
  logic                       ram_we;
  logic [ttps_pkg::IDX_W-1:0] ram_waddr;
  ttps_pkg::entry_t           ram_wdata;
  ttps_pkg::entry_t           slot;
  logic [ttps_pkg::ENTRY_W-1:0] ram_rdata;
  logic signed [ttps_pkg::SCORE_W-1:0] stored_score;
  ttps_pkg::probe_res_t       pres;
  ttps_pkg::act_t             act;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign look_done = (state == ST_LOOK) && out_free;
  assign clr_last  = (clr_addr == ttps_pkg::IDX_W'(ttps_pkg::ENTRIES - 1));
  assign act       = ttps_pkg::act_t'(action);
  assign slot      = ttps_pkg::entry_t'(ram_rdata);

  assign rsp.new_writes  = new_write_total;
  assign rsp.over_writes = over_write_total;
  assign rsp.hit_count   = hit_total;

  always_ff @(posedge clk) begin
    if (accept) begin
      action       <= req.action;
      position_key <= req.position_key;
      store_move   <= req.store_move;
      store_score  <= req.store_score;
      bound_kind   <= req.bound_kind;
      req_depth    <= req.req_depth;
      ply_now      <= req.ply_now;
      alpha_bound  <= req.alpha_bound;
      beta_bound   <= req.beta_bound;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_last) state_next = clr_report ? ST_FIN : ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          state_next = (req.action == ttps_pkg::ACT_CLEAR) ? ST_CLEAR : ST_LOOK;
        end
      end
      ST_LOOK: if (out_free) state_next = ST_IDLE;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      clr_report <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (accept) begin
        clr_addr   <= '0;
        clr_report <= (req.action == ttps_pkg::ACT_CLEAR);
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = position_key[ttps_pkg::IDX_W-1:0];
    ram_wdata = '0;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
    end else if (look_done && act == ttps_pkg::ACT_STORE) begin
      ram_we          = 1'b1;
      ram_wdata.key   = position_key;
      ram_wdata.move  = store_move;
      ram_wdata.score = stored_score;
      ram_wdata.depth = req_depth;
      ram_wdata.bound = bound_kind;
    end
  end

  ttps_ram #(
    .WIDTH (ttps_pkg::ENTRY_W),
    .DEPTH (ttps_pkg::ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (req.position_key[ttps_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  ttps_score_unit u_score (
    .slot         (slot),
    .key          (position_key),
    .store_score  (store_score),
    .req_depth    (req_depth),
    .ply_now      (ply_now),
    .alpha_bound  (alpha_bound),
    .beta_bound   (beta_bound),
    .stored_score (stored_score),
    .res          (pres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      new_write_total  <= '0;
      over_write_total <= '0;
      hit_total        <= '0;
    end else if (look_done) begin
      unique case (act)
        ttps_pkg::ACT_STORE: begin
          if (slot.key == '0) new_write_total <= new_write_total + 1'b1;
          else                over_write_total <= over_write_total + 1'b1;
        end
        ttps_pkg::ACT_PROBE: if (pres.hit) hit_total <= hit_total + 1'b1;
        default: ;
      endcase
    end else if (state == ST_FIN && out_free) begin
      new_write_total <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (look_done || (state == ST_FIN && out_free)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (look_done && act == ttps_pkg::ACT_PROBE) begin
      rsp.matched     <= pres.matched;
      rsp.found_move  <= pres.move;
      rsp.usable      <= pres.usable;
      rsp.found_score <= pres.score;
    end else if (look_done || (state == ST_FIN && out_free)) begin
      rsp.matched     <= 1'b0;
      rsp.found_move  <= '0;
      rsp.usable      <= 1'b0;
      rsp.found_score <= '0;
    end
  end

endmodule

`default_nettype wire
